/* rtl/ibr_pkg.sv */
// ----------------------------------------------------------------------------
// ibr_pkg: shared types and constants of the batch reassembler
// beat layouts, result kinds, error codes and the decoded item record
// ----------------------------------------------------------------------------
package ibr_pkg;

    localparam int DEF_MAX_BATCH = 16;

    localparam int S_DATA_W = 208;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 152;
    localparam int M_USER_W = 2;

    // result kinds
    localparam logic [1:0] KIND_SLOT  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_MISMATCH = 3'd1;
    localparam logic [2:0] ERR_RANGE    = 3'd2;
    localparam logic [2:0] ERR_NOT_BUF  = 3'd3;
    localparam logic [2:0] ERR_OVER_CAP = 3'd4;

    // input beat after classification
    typedef struct packed {
        logic [31:0] batch_index;
        logic [7:0]  batch_size;
        logic [7:0]  item_index;
        logic [63:0] item_time;
        logic [31:0] item_sequence;
        logic        payload_present;
        logic [31:0] payload_handle;
        logic [31:0] payload_sequence;
        logic        size_zero;
        logic        size_over;
        logic        idx_oor;
        logic        not_buffer;
    } item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  slot_number;
        logic        slot_filled;
        logic [31:0] slot_handle;
        logic [31:0] batch_sequence;
        logic [63:0] batch_time;
        logic        time_valid;
        logic [7:0]  slot_total;
        logic [2:0]  error_code;
        logic        last_of_batch;
    } result_t;

endpackage

/* rtl/ibr_front.sv */
// ----------------------------------------------------------------------------
// ibr_front: input side of the batch reassembler
// unpacks and classifies input beats and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module ibr_front #(
    parameter int MAX_BATCH = ibr_pkg::DEF_MAX_BATCH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ibr_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic [ibr_pkg::S_USER_W-1:0]  s_tuser,
    output logic                          q_valid,
    output ibr_pkg::item_t                q_item,
    input  logic                          q_pop
);

    ibr_pkg::item_t q_mem_reg [2];
    logic [0:0]     wr_ptr_reg, wr_ptr_next;
    logic [0:0]     rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    ibr_pkg::item_t in_item;
    logic           push;

    always_comb begin
        in_item.batch_index      = s_tdata[31:0];
        in_item.batch_size       = s_tdata[39:32];
        in_item.item_index       = s_tdata[47:40];
        in_item.item_time        = s_tdata[111:48];
        in_item.item_sequence    = s_tdata[143:112];
        in_item.payload_handle   = s_tdata[175:144];
        in_item.payload_sequence = s_tdata[207:176];
        in_item.payload_present  = s_tuser[0];
        in_item.size_zero        = (s_tdata[39:32] == 8'd0);
        in_item.size_over        = (s_tdata[39:32] > 8'(MAX_BATCH));
        in_item.idx_oor          = (s_tdata[47:40] >= s_tdata[39:32]);
        in_item.not_buffer       = s_tuser[0] && !s_tuser[1];
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* rtl/ibr_back.sv */
// ----------------------------------------------------------------------------
// ibr_back: batch engine of the batch reassembler
// keeps the open batch, the slot store, walks the slots on close and
// drives the output register
// ----------------------------------------------------------------------------
module ibr_back #(
    parameter int MAX_BATCH = ibr_pkg::DEF_MAX_BATCH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  ibr_pkg::item_t   q_item,
    output logic             q_pop,
    output logic             out_valid,
    output ibr_pkg::result_t out_data,
    input  logic             out_ready
);

    localparam int AW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
    localparam int CW = $clog2(MAX_BATCH + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_APPLY = 4'b0010,
        ST_SEQ   = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    ibr_pkg::item_t         cur_reg, cur_next;
    logic                   open_reg, open_next;
    logic [31:0]            open_index_reg, open_index_next;
    logic [CW-1:0]          open_size_reg, open_size_next;
    logic [MAX_BATCH-1:0]   arrived_reg, arrived_next;
    logic [CW-1:0]          consumed_reg, consumed_next;
    logic [63:0]            shared_time_reg, shared_time_next;
    logic                   time_set_reg, time_set_next;
    logic                   agree_reg, agree_next;
    logic [AW-1:0]          emit_idx_reg, emit_idx_next;
    logic                   ret_apply_reg, ret_apply_next;
    logic                   any_filled_reg, any_filled_next;
    logic                   out_valid_reg, out_valid_next;
    ibr_pkg::result_t       out_reg, out_next;

    // slot store, no reset: only slots with an arrived bit are read out
    logic [31:0]            slot_ref_mem [MAX_BATCH];
    logic [31:0]            slot_seq_mem [MAX_BATCH];
    logic [MAX_BATCH-1:0]   has_pay_reg;
    logic [31:0]            ref_rd_reg;
    logic [31:0]            seq_rd_reg;

    logic                   slot_we;
    logic [AW-1:0]          slot_wr_addr;
    logic [AW-1:0]          ref_addr;
    logic                   out_free;
    logic [MAX_BATCH-1:0]   filled_map;
    logic [MAX_BATCH-1:0]   low_onehot;
    logic [AW-1:0]          low_idx;
    logic                   emit_last;
    logic                   tv;

    assign out_free   = !out_valid_reg || out_ready;
    assign filled_map = arrived_reg & has_pay_reg;
    assign low_onehot = filled_map & (~filled_map + 1'b1);
    assign emit_last  = ((CW'(emit_idx_reg) + CW'(1)) == open_size_reg);
    assign tv         = agree_reg && time_set_reg;
    assign slot_wr_addr = cur_reg.item_index[AW-1:0];
    assign out_valid  = out_valid_reg;
    assign out_data   = out_reg;

    always_comb begin
        low_idx = '0;
        for (int i = 0; i < MAX_BATCH; i++) begin
            if (low_onehot[i]) begin
                low_idx = low_idx | AW'(i);
            end
        end
    end

    always_comb begin
        logic                 drop;
        logic [2:0]           err;
        logic [MAX_BATCH-1:0] base_map;
        logic [CW-1:0]        base_size;
        logic [CW-1:0]        cons_inc;
        logic                 slot_f;

        drop             = 1'b0;
        err              = ibr_pkg::ERR_NONE;
        base_map         = open_reg ? arrived_reg : '0;
        base_size        = open_reg ? open_size_reg : CW'(cur_reg.batch_size);
        cons_inc         = (open_reg ? consumed_reg : '0) + CW'(1);
        slot_f           = arrived_reg[emit_idx_reg] && has_pay_reg[emit_idx_reg];

        state_next       = state_reg;
        cur_next         = cur_reg;
        open_next        = open_reg;
        open_index_next  = open_index_reg;
        open_size_next   = open_size_reg;
        arrived_next     = arrived_reg;
        consumed_next    = consumed_reg;
        shared_time_next = shared_time_reg;
        time_set_next    = time_set_reg;
        agree_next       = agree_reg;
        emit_idx_next    = emit_idx_reg;
        ret_apply_next   = ret_apply_reg;
        any_filled_next  = any_filled_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_next         = out_reg;
        q_pop            = 1'b0;
        slot_we          = 1'b0;
        ref_addr         = emit_idx_reg;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    cur_next = q_item;
                    q_pop    = 1'b1;
                    // another batch index closes the open batch first
                    if (open_reg && (q_item.batch_index != open_index_reg)) begin
                        ret_apply_next = 1'b1;
                        state_next     = ST_SEQ;
                    end else begin
                        state_next = ST_APPLY;
                    end
                end
            end

            ST_APPLY: begin
                if (out_free) begin
                    if (!open_reg && cur_reg.size_zero) begin
                        out_next                = '0;
                        out_next.result_kind    = ibr_pkg::KIND_EMPTY;
                        out_next.batch_sequence = cur_reg.item_sequence;
                        out_next.batch_time     = cur_reg.item_time;
                        out_next.time_valid     = 1'b1;
                        out_next.last_of_batch  = 1'b1;
                        out_valid_next          = 1'b1;
                        state_next              = ST_IDLE;
                    end else begin
                        if (!open_reg && cur_reg.size_over) begin
                            err = ibr_pkg::ERR_OVER_CAP;
                        end else if (open_reg &&
                                     (cur_reg.batch_size != 8'(open_size_reg))) begin
                            err = ibr_pkg::ERR_MISMATCH;
                        end else if (cur_reg.idx_oor) begin
                            err = ibr_pkg::ERR_RANGE;
                        end else if (cur_reg.not_buffer) begin
                            err = ibr_pkg::ERR_NOT_BUF;
                        end

                        if (err != ibr_pkg::ERR_NONE) begin
                            out_next               = '0;
                            out_next.result_kind   = ibr_pkg::KIND_ERROR;
                            out_next.error_code    = err;
                            out_next.last_of_batch = 1'b1;
                            out_valid_next         = 1'b1;
                            drop                   = 1'b1;
                            state_next             = ST_IDLE;
                        end else begin
                            slot_we         = 1'b1;
                            open_next       = 1'b1;
                            open_index_next = cur_reg.batch_index;
                            open_size_next  = base_size;
                            arrived_next    = base_map | (MAX_BATCH'(1) << slot_wr_addr);
                            consumed_next   = cons_inc;
                            if (!open_reg || !time_set_reg) begin
                                shared_time_next = cur_reg.item_time;
                                time_set_next    = 1'b1;
                                agree_next       = 1'b1;
                            end else if (shared_time_reg != cur_reg.item_time) begin
                                agree_next = 1'b0;
                            end
                            // consumed never trails arrived, so it alone closes
                            if (cons_inc >= base_size) begin
                                ret_apply_next = 1'b0;
                                state_next     = ST_SEQ;
                            end else begin
                                state_next = ST_IDLE;
                            end
                        end
                    end
                end
            end

            ST_SEQ: begin
                any_filled_next = |filled_map;
                emit_idx_next   = '0;
                state_next      = ST_EMIT;
            end

            ST_EMIT: begin
                if (out_free) begin
                    out_next                = '0;
                    out_next.result_kind    = ibr_pkg::KIND_SLOT;
                    out_next.slot_number    = 8'(emit_idx_reg);
                    out_next.slot_filled    = slot_f;
                    out_next.slot_handle    = slot_f ? ref_rd_reg : 32'd0;
                    out_next.batch_sequence = any_filled_reg ? seq_rd_reg : 32'd0;
                    out_next.batch_time     = tv ? shared_time_reg : 64'd0;
                    out_next.time_valid     = tv;
                    out_next.slot_total     = 8'(open_size_reg);
                    out_next.error_code     = ibr_pkg::ERR_NONE;
                    out_next.last_of_batch  = emit_last;
                    out_valid_next          = 1'b1;
                    if (emit_last) begin
                        drop          = 1'b1;
                        emit_idx_next = '0;
                        state_next    = ret_apply_reg ? ST_APPLY : ST_IDLE;
                    end else begin
                        emit_idx_next = emit_idx_reg + 1'b1;
                        ref_addr      = emit_idx_reg + 1'b1;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (drop) begin
            open_next        = 1'b0;
            open_index_next  = '0;
            open_size_next   = '0;
            arrived_next     = '0;
            consumed_next    = '0;
            shared_time_next = '0;
            time_set_next    = 1'b0;
            agree_next       = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            open_reg        <= 1'b0;
            open_index_reg  <= '0;
            open_size_reg   <= '0;
            arrived_reg     <= '0;
            consumed_reg    <= '0;
            shared_time_reg <= '0;
            time_set_reg    <= 1'b0;
            agree_reg       <= 1'b1;
            emit_idx_reg    <= '0;
            ret_apply_reg   <= 1'b0;
            any_filled_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            open_reg        <= open_next;
            open_index_reg  <= open_index_next;
            open_size_reg   <= open_size_next;
            arrived_reg     <= arrived_next;
            consumed_reg    <= consumed_next;
            shared_time_reg <= shared_time_next;
            time_set_reg    <= time_set_next;
            agree_reg       <= agree_next;
            emit_idx_reg    <= emit_idx_next;
            ret_apply_reg   <= ret_apply_next;
            any_filled_reg  <= any_filled_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    // slot store write and registered reads
    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_ref_mem[slot_wr_addr] <= cur_reg.payload_present ?
                                          cur_reg.payload_handle : 32'd0;
            slot_seq_mem[slot_wr_addr] <= cur_reg.payload_sequence;
            has_pay_reg[slot_wr_addr]  <= cur_reg.payload_present;
        end
        ref_rd_reg <= slot_ref_mem[ref_addr];
        if (state_reg == ST_SEQ) begin
            seq_rd_reg <= slot_seq_mem[low_idx];
        end
    end

endmodule

/* rtl/indexed_batch_reassembler_unit.sv */
// ----------------------------------------------------------------------------
// indexed_batch_reassembler_unit: fragment reassembly buffer
// collects indexed items into batches of up to MAX_BATCH slots and streams
// each closed batch out one slot per beat
// ----------------------------------------------------------------------------
// usage:
//   the s_ channel takes one item per beat; the m_ channel gives results,
//   m_tlast marks the final result of a batch and every lone result
//   (empty batch or error); m_tuser carries the result kind
//   a batch closes when its declared count of items has been taken, or
//   when an item with another batch index shows up; that item is then
//   applied once the closed batch has been walked
// flow:
//   an item reaches the engine through a two-entry queue; a lone result
//   passes a queue entry and the engine item register into the output
//   register; an item that closes nothing goes through IDLE and APPLY; a
//   batch close adds SEQ for the lowest-filled-slot lookup, then the EMIT
//   walk reads one slot store entry a cycle while the output is free
// reset:
//   aresetn drops any open batch and empties queue and output register;
//   the slot store keeps its contents, which are never read before written
// back-pressure:
//   a low m_tready holds the output register and stalls the slot walk; the
//   queue keeps taking items until both entries are full
// ----------------------------------------------------------------------------
module indexed_batch_reassembler_unit #(
    parameter int MAX_BATCH = ibr_pkg::DEF_MAX_BATCH
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    // batch_index, batch_size, item_index, item_time, item_sequence,
    // payload_handle, payload_sequence
    input  logic [ibr_pkg::S_DATA_W-1:0]  s_tdata,
    // payload_present, payload_is_buffer
    input  logic [ibr_pkg::S_USER_W-1:0]  s_tuser,

    output logic                          m_tvalid,
    input  logic                          m_tready,
    // slot_number, slot_filled, slot_handle, batch_sequence, batch_time,
    // time_valid, slot_total, error_code, zero pad
    output logic [ibr_pkg::M_DATA_W-1:0]  m_tdata,
    // result_kind
    output logic [ibr_pkg::M_USER_W-1:0]  m_tuser,
    // last_of_batch
    output logic                          m_tlast
);

    logic             q_valid;
    ibr_pkg::item_t   q_item;
    logic             q_pop;
    ibr_pkg::result_t res;

    // front: unpack, classify, queue
    ibr_front #(
        .MAX_BATCH (MAX_BATCH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // back: batch state, slot store, slot walk and output register
    ibr_back #(
        .MAX_BATCH (MAX_BATCH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_data  (res),
        .out_ready (m_tready)
    );

    // result beat packing, first field in the lowest bits
    assign m_tdata = {3'b000,
                      res.error_code,
                      res.slot_total,
                      res.time_valid,
                      res.batch_time,
                      res.batch_sequence,
                      res.slot_handle,
                      res.slot_filled,
                      res.slot_number};
    assign m_tuser = res.result_kind;
    assign m_tlast = res.last_of_batch;

endmodule
